[hw/rtl/hbcm_pkg.sv]
// Shared types and constants for the hashed buffer cache manager.
// Depends on nothing; used by hbcm_mod, the top module and the testbench.
package hbcm_pkg;

	localparam int NUM_BUFFERS = 30;
	localparam int NUM_BUCKETS = 13;
	localparam int IDXW = $clog2(NUM_BUFFERS);
	localparam int BKW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int DEVW = 16;
	localparam int BLKW = 31;
	localparam int REFW = 8;

	// Remainder by the bucket count of 13: 2**12 is 1 modulo 13, so 12-bit chunks
	// of a block number add up to the same remainder; the sum (below 2**14) is then
	// divided exactly by multiplying with 20165 and dropping 18 bits.
	localparam int MOD_FOLDW = 12;
	localparam int MOD_SUMW = MOD_FOLDW + 2;
	localparam int MOD_RECIP = 20165;
	localparam int MOD_SHIFT = 18;

	typedef enum logic [1:0] {
		OP_GET = 2'd0,
		OP_RELEASE = 2'd1,
		OP_PIN = 2'd2,
		OP_UNPIN = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOFREE = 2'd1,
		ST_COUNT = 2'd2
	} status_t;

	// One tag entry as held in the tag memory
	typedef struct packed {
		logic [DEVW-1:0] dev;
		logic [BLKW-1:0] blk;
		logic valid;
		logic [REFW-1:0] refcnt;
		logic [BKW-1:0] bucket;
		logic [IDXW-1:0] rank;
	} entry_t;

	localparam int ENTW = $bits(entry_t);

endpackage

[hw/rtl/hbcm_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
module hbcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[hw/rtl/hbcm_mod.sv]
// Remainder of a block number by the bucket count, pipelined as
// chunk fold, reciprocal multiply, subtract. Depends on hbcm_pkg.
module hbcm_mod (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [hbcm_pkg::BLKW-1:0] value,
	output logic done,
	output logic [hbcm_pkg::BKW-1:0] rem
);
	import hbcm_pkg::*;

	logic v_s1, v_s2;
	logic [MOD_SUMW-1:0] sum_s1, sum_s2;
	logic [MOD_SUMW-1:0] quo_s2;
	logic [MOD_SUMW-1:0] fold;
	logic [MOD_SUMW+MOD_SHIFT-1:0] prod;
	logic [MOD_SUMW-1:0] diff;

	// fold 12-bit chunks, estimate quotient, take what is left
	always_comb begin
		fold = MOD_SUMW'(value[MOD_FOLDW-1:0]) +
			MOD_SUMW'(value[2*MOD_FOLDW-1:MOD_FOLDW]) +
			MOD_SUMW'(value[BLKW-1:2*MOD_FOLDW]);
		prod = (MOD_SUMW+MOD_SHIFT)'(sum_s1) * (MOD_SUMW+MOD_SHIFT)'(MOD_RECIP);
		diff = sum_s2 - MOD_SUMW'(quo_s2 * MOD_SUMW'(NUM_BUCKETS));
	end

	// stage valids, done pulses with the remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			done <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sum_s1 <= fold;
		end
		if (v_s1) begin
			sum_s2 <= sum_s1;
			quo_s2 <= prod[MOD_SUMW+MOD_SHIFT-1:MOD_SHIFT];
		end
		if (v_s2) begin
			rem <= diff[BKW-1:0];
		end
	end
endmodule

[hw/rtl/hashed_buffer_cache_manager.sv]
// Hashed buffer cache tag manager: tag memory, remainder unit and sequencer.
// Get: remainder, scan of all buffers, decide, respond; a steal adds a rank sweep.
// Release/pin/unpin: read, update, respond; a bad index skips the read, and a freeing release adds remainder and sweep.
// One item at a time: next transfer the cycle after the result loads; the load waits on out_ready.
// After reset a clearing pass loads the tag memory first.
// Depends on hbcm_pkg, hbcm_ram and hbcm_mod.
module hashed_buffer_cache_manager (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] opcode,
	input logic [15:0] dev_number,
	input logic [30:0] block_number,
	input logic [4:0] buffer_index,
	output logic out_valid,
	input logic out_ready,
	output logic [4:0] result_buffer,
	output logic hit,
	output logic needs_disk_read,
	output logic [1:0] status
);
	import hbcm_pkg::*;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_GMOD, S_SCAN, S_DECIDE, S_RDW, S_RMOD, S_SWEEP, S_RESP
	} state_t;

	state_t state_q;
	logic [IDXW:0] cnt_q;
	logic [BKW-1:0] bkt_init_q;
	logic rd_s1;
	logic [IDXW-1:0] addr_s1;

	logic [1:0] op_q;
	logic [DEVW-1:0] dev_q;
	logic [BLKW-1:0] blk_q;
	logic [IDXW-1:0] idx_q;
	logic [BKW-1:0] home_q;

	logic m_found_q, f_found_q;
	logic [IDXW-1:0] m_idx_q, f_idx_q;
	entry_t m_ent_q, f_ent_q;
	logic [BKW-1:0] f_dist_q;

	logic [IDXW-1:0] tgt_q;
	logic [IDXW-1:0] old_rank_q;
	entry_t new_q;

	logic [4:0] res_buf_q;
	logic res_hit_q, res_rd_q;
	status_t res_st_q;

	logic ram_we;
	logic [IDXW-1:0] ram_waddr, ram_raddr;
	entry_t ram_wdata, ram_rdata;
	logic [ENTW-1:0] rdata_raw;

	logic mod_start, mod_done;
	logic [BLKW-1:0] mod_value;
	logic [BKW-1:0] mod_rem;

	logic issue;
	logic [BKW:0] dist_wide;
	logic [BKW-1:0] bkt_gap;
	logic is_match, is_free_better;
	logic idx_bad;
	entry_t init_ent, upd_ent;

	assign ram_rdata = entry_t'(rdata_raw);

	hbcm_ram #(.WIDTH(ENTW), .DEPTH(NUM_BUFFERS)) u_tags (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(rdata_raw)
	);

	hbcm_mod u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .value(mod_value),
		.done(mod_done), .rem(mod_rem)
	);

	assign in_ready = (state_q == S_IDLE);
	assign idx_bad = (32'(buffer_index) >= NUM_BUFFERS);
	assign issue = (state_q == S_SCAN || state_q == S_SWEEP) &&
		(cnt_q < (IDXW+1)'(NUM_BUFFERS));

	// read address: the addressed buffer on a transfer, else the sweep counter
	assign ram_raddr = (state_q == S_IDLE) ? IDXW'(buffer_index) : cnt_q[IDXW-1:0];

	// remainder unit start: block of a get, or stored block of a released buffer
	always_comb begin
		mod_start = 1'b0;
		mod_value = block_number;
		if (state_q == S_IDLE && in_valid && opcode == OP_GET) begin
			mod_start = 1'b1;
		end else if (state_q == S_RDW && op_q == OP_RELEASE &&
				ram_rdata.refcnt == REFW'(1)) begin
			mod_start = 1'b1;
			mod_value = ram_rdata.blk;
		end
	end

	// scan comparisons: cyclic bucket distance from home and candidate tests
	always_comb begin
		dist_wide = ({1'b0, ram_rdata.bucket} >= {1'b0, home_q}) ?
			{1'b0, ram_rdata.bucket} - {1'b0, home_q} :
			{1'b0, ram_rdata.bucket} + (BKW+1)'(NUM_BUCKETS) - {1'b0, home_q};
		bkt_gap = dist_wide[BKW-1:0];
		is_match = (ram_rdata.bucket == home_q) && (ram_rdata.dev == dev_q) &&
			(ram_rdata.blk == blk_q) && (!m_found_q || ram_rdata.rank < m_ent_q.rank);
		is_free_better = (ram_rdata.refcnt == '0) && (!f_found_q || bkt_gap < f_dist_q ||
			(bkt_gap == f_dist_q && ram_rdata.rank > f_ent_q.rank));
	end

	// write port: clearing pass, single updates and rank sweep
	always_comb begin
		init_ent = '0;
		init_ent.bucket = bkt_init_q;
		init_ent.rank = IDXW'(NUM_BUFFERS - 1) - cnt_q[IDXW-1:0];
		upd_ent = ram_rdata;
		ram_we = 1'b0;
		ram_waddr = addr_s1;
		ram_wdata = ram_rdata;
		case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
				ram_waddr = cnt_q[IDXW-1:0];
				ram_wdata = init_ent;
			end
			S_DECIDE: begin
				if (m_found_q) begin
					upd_ent = m_ent_q;
					upd_ent.refcnt = m_ent_q.refcnt + 1'b1;
					upd_ent.valid = 1'b1;
					ram_we = (m_ent_q.refcnt != '1);
					ram_waddr = m_idx_q;
					ram_wdata = upd_ent;
				end else if (f_found_q && f_dist_q == '0) begin
					upd_ent = f_ent_q;
					upd_ent.dev = dev_q;
					upd_ent.blk = blk_q;
					upd_ent.valid = 1'b1;
					upd_ent.refcnt = REFW'(1);
					ram_we = 1'b1;
					ram_waddr = f_idx_q;
					ram_wdata = upd_ent;
				end
			end
			S_RDW: begin
				ram_waddr = idx_q;
				if (op_q == OP_PIN) begin
					upd_ent.refcnt = ram_rdata.refcnt + 1'b1;
					ram_we = (ram_rdata.refcnt != '1);
				end else begin
					upd_ent.refcnt = ram_rdata.refcnt - 1'b1;
					ram_we = (ram_rdata.refcnt != '0) &&
						!(op_q == OP_RELEASE && ram_rdata.refcnt == REFW'(1));
				end
				ram_wdata = upd_ent;
			end
			S_SWEEP: begin
				ram_we = rd_s1;
				if (addr_s1 == tgt_q) begin
					ram_wdata = new_q;
				end else if (ram_rdata.rank < old_rank_q) begin
					upd_ent.rank = ram_rdata.rank + 1'b1;
					ram_wdata = upd_ent;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cnt_q <= '0;
			bkt_init_q <= '0;
			rd_s1 <= 1'b0;
			out_valid <= 1'b0;
			m_found_q <= 1'b0;
			f_found_q <= 1'b0;
		end else begin
			rd_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			// result register: load when free or being taken, else clear on transfer
			if (state_q == S_RESP && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					bkt_init_q <= (bkt_init_q == BKW'(NUM_BUCKETS - 1)) ?
						'0 : bkt_init_q + 1'b1;
					if (cnt_q == (IDXW+1)'(NUM_BUFFERS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						if (opcode == OP_GET) begin
							state_q <= S_GMOD;
						end else if (idx_bad) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_RDW;
						end
					end
				end
				S_GMOD: begin
					if (mod_done) begin
						cnt_q <= '0;
						m_found_q <= 1'b0;
						f_found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_s1) begin
						if (is_match) begin
							m_found_q <= 1'b1;
						end
						if (is_free_better) begin
							f_found_q <= 1'b1;
						end
						if (addr_s1 == IDXW'(NUM_BUFFERS - 1)) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					if (!m_found_q && f_found_q && f_dist_q != '0) begin
						cnt_q <= '0;
						state_q <= S_SWEEP;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RDW: begin
					if (mod_start) begin
						state_q <= S_RMOD;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RMOD: begin
					if (mod_done) begin
						cnt_q <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					if (rd_s1 && addr_s1 == IDXW'(NUM_BUFFERS - 1)) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_valid || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q[IDXW-1:0];
		case (state_q)
			S_IDLE: begin
				op_q <= opcode;
				dev_q <= dev_number;
				blk_q <= block_number;
				idx_q <= IDXW'(buffer_index);
				res_buf_q <= buffer_index;
				res_hit_q <= 1'b0;
				res_rd_q <= 1'b0;
				res_st_q <= idx_bad ? ST_COUNT : ST_OK;
			end
			S_GMOD: begin
				if (mod_done) begin
					home_q <= mod_rem;
				end
			end
			S_SCAN: begin
				if (rd_s1 && is_match) begin
					m_idx_q <= addr_s1;
					m_ent_q <= ram_rdata;
				end
				if (rd_s1 && is_free_better) begin
					f_idx_q <= addr_s1;
					f_ent_q <= ram_rdata;
					f_dist_q <= bkt_gap;
				end
			end
			S_DECIDE: begin
				if (m_found_q) begin
					res_buf_q <= 5'(m_idx_q);
					res_hit_q <= 1'b1;
					res_rd_q <= (m_ent_q.refcnt != '1) && !m_ent_q.valid;
					res_st_q <= (m_ent_q.refcnt == '1) ? ST_COUNT : ST_OK;
				end else if (f_found_q) begin
					res_buf_q <= 5'(f_idx_q);
					res_hit_q <= 1'b0;
					res_rd_q <= 1'b1;
					res_st_q <= ST_OK;
				end else begin
					res_buf_q <= '0;
					res_hit_q <= 1'b0;
					res_rd_q <= 1'b0;
					res_st_q <= ST_NOFREE;
				end
				// stolen buffer moves home as most recent
				tgt_q <= f_idx_q;
				old_rank_q <= f_ent_q.rank;
				new_q <= '{dev: dev_q, blk: blk_q, valid: 1'b1, refcnt: REFW'(1),
					bucket: home_q, rank: IDXW'(0)};
			end
			S_RDW: begin
				if ((op_q == OP_PIN && ram_rdata.refcnt == '1) ||
						(op_q != OP_PIN && ram_rdata.refcnt == '0)) begin
					res_st_q <= ST_COUNT;
				end
				tgt_q <= idx_q;
				old_rank_q <= ram_rdata.rank;
				new_q <= '{dev: ram_rdata.dev, blk: ram_rdata.blk, valid: ram_rdata.valid,
					refcnt: REFW'(0), bucket: ram_rdata.bucket, rank: IDXW'(0)};
			end
			S_RMOD: begin
				if (mod_done) begin
					new_q.bucket <= mod_rem;
				end
			end
			S_RESP: begin
				if (!out_valid || out_ready) begin
					result_buffer <= res_buf_q;
					hit <= res_hit_q;
					needs_disk_read <= res_rd_q;
					status <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	// result consistency checks
	a_nofree: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_NOFREE) |-> (result_buffer == '0 && !hit))
		else $error("no-free result carries a buffer or hit");
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && needs_disk_read) |-> (status == ST_OK))
		else $error("disk read flagged on a failed request");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_SWEEP) |-> !in_ready)
		else $error("transfer accepted during a memory sweep");
endmodule

[verif/tb_top.sv]
// Self-checking testbench for the hashed buffer cache manager.
// Holds its own tag/recency predictor and drives a directed table, count-ceiling and fill runs, then random traffic.
// Depends on hbcm_pkg and the hashed_buffer_cache_manager RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import hbcm_pkg::*;

	localparam int RANDOM_ITEMS = 1310;
	localparam longint CYCLE_LIMIT = 1200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = '0;
	logic [15:0] dev_number = '0;
	logic [30:0] block_number = '0;
	logic [4:0] buffer_index = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [4:0] result_buffer;
	logic hit;
	logic needs_disk_read;
	logic [1:0] status;

	typedef struct packed {
		logic [4:0] buf_id;
		logic hit;
		logic rd;
		logic [1:0] st;
	} cache_reply_t;

	// Directed row: request plus optional typed-in reply
	typedef struct {
		opcode_t op;
		logic [15:0] dev;
		logic [30:0] blk;
		logic [4:0] idx;
		bit known;
		cache_reply_t reply;
	} stim_row_t;

	// Predictor copy of the tag state
	logic [15:0] tag_dev [NUM_BUFFERS];
	logic [30:0] tag_blk [NUM_BUFFERS];
	bit tag_valid [NUM_BUFFERS];
	int unsigned tag_cnt [NUM_BUFFERS];
	int unsigned tag_bucket [NUM_BUFFERS];
	int unsigned lru_rank [NUM_BUFFERS];

	cache_reply_t pending_replies[$];
	int errors = 0;
	longint cycle = 0;
	bit stim_done = 1'b0;
	bit hold_rx = 1'b0;

	hashed_buffer_cache_manager DUT (.*);

	always #6 clk = ~clk;

	function automatic void cache_clear();
		for (int i = 0; i < NUM_BUFFERS; i++) begin
			tag_dev[i] = '0;
			tag_blk[i] = '0;
			tag_valid[i] = 0;
			tag_cnt[i] = 0;
			tag_bucket[i] = i % NUM_BUCKETS;
			lru_rank[i] = NUM_BUFFERS - 1 - i;
		end
	endfunction

	function automatic void promote(int b);
		int unsigned old;
		old = lru_rank[b];
		for (int j = 0; j < NUM_BUFFERS; j++)
			if (lru_rank[j] < old) lru_rank[j]++;
		lru_rank[b] = 0;
	endfunction

	function automatic int oldest_free(int unsigned bk);
		int pick;
		pick = -1;
		for (int j = 0; j < NUM_BUFFERS; j++)
			if (tag_bucket[j] == bk && tag_cnt[j] == 0 &&
					(pick < 0 || lru_rank[j] > lru_rank[pick]))
				pick = j;
		return pick;
	endfunction

	// Apply one request to the predictor and return its reply
	function automatic cache_reply_t cache_predict(opcode_t op, logic [15:0] dev,
			logic [30:0] blk, logic [4:0] idx);
		cache_reply_t r;
		int unsigned home;
		int unsigned bk;
		int b;
		r = '0;
		if (op == OP_GET) begin
			home = blk % NUM_BUCKETS;
			b = -1;
			for (int j = 0; j < NUM_BUFFERS; j++)
				if (tag_bucket[j] == home && tag_dev[j] == dev && tag_blk[j] == blk &&
						(b < 0 || lru_rank[j] < lru_rank[b]))
					b = j;
			if (b >= 0) begin
				r.buf_id = 5'(b);
				r.hit = 1'b1;
				if (tag_cnt[b] == 255) begin
					r.st = ST_COUNT;
					return r;
				end
				tag_cnt[b]++;
				r.rd = !tag_valid[b];
				tag_valid[b] = 1'b1;
				r.st = ST_OK;
				return r;
			end
			b = oldest_free(home);
			if (b < 0) begin
				bk = (home + 1) % NUM_BUCKETS;
				while (bk != home) begin
					b = oldest_free(bk);
					if (b >= 0) begin
						tag_bucket[b] = home;
						promote(b);
						break;
					end
					bk = (bk + 1) % NUM_BUCKETS;
				end
			end
			if (b < 0) begin
				r.st = ST_NOFREE;
				return r;
			end
			tag_dev[b] = dev;
			tag_blk[b] = blk;
			tag_cnt[b] = 1;
			tag_valid[b] = 1'b1;
			r.buf_id = 5'(b);
			r.rd = 1'b1;
			r.st = ST_OK;
			return r;
		end
		r.buf_id = idx;
		r.st = ST_COUNT;
		if (idx >= NUM_BUFFERS) return r;
		if (op == OP_PIN) begin
			if (tag_cnt[idx] == 255) return r;
			tag_cnt[idx]++;
		end else begin
			if (tag_cnt[idx] == 0) return r;
			tag_cnt[idx]--;
			if (op == OP_RELEASE && tag_cnt[idx] == 0) begin
				tag_bucket[idx] = tag_blk[idx] % NUM_BUCKETS;
				promote(idx);
			end
		end
		r.st = ST_OK;
		return r;
	endfunction

	// Index of the buffer that holds the ceiling-count block
	function automatic int cache_predict_id();
		for (int j = 0; j < NUM_BUFFERS; j++)
			if (tag_dev[j] == 16'hBEEF && tag_blk[j] == 31'd100) return j;
		return 0;
	endfunction

	// Offer one transfer and wait for it to be taken; valid drops only for a gap
	task automatic send_request(opcode_t op, logic [15:0] dev, logic [30:0] blk,
			logic [4:0] idx, bit known, cache_reply_t want);
		cache_reply_t r;
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r = cache_predict(op, dev, blk, idx);
		if (known && r !== want) begin
			$error("directed row: predictor %h, table %h", r, want);
			errors++;
		end
		pending_replies.push_back(known ? want : r);
		in_valid <= 1'b1;
		opcode <= op;
		dev_number <= dev;
		block_number <= blk;
		buffer_index <= idx;
		do @(posedge clk); while (!in_ready);
	endtask

	// Random request: gets and releases on a small working set, with some pins and unpins
	task automatic send_random();
		int c;
		logic [15:0] dev;
		logic [30:0] blk;
		logic [4:0] idx;
		c = $urandom_range(0, 99);
		dev = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
		blk = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 40));
		idx = ($urandom_range(0, 15) == 0) ? 5'($urandom) : 5'($urandom_range(0, 29));
		if (c < 45)
			send_request(OP_GET, dev, blk, idx, 0, '0);
		else if (c < 85)
			send_request(OP_RELEASE, dev, blk, idx, 0, '0);
		else if (c < 92)
			send_request(OP_PIN, dev, blk, idx, 0, '0);
		else
			send_request(OP_UNPIN, dev, blk, idx, 0, '0);
	endtask

	// Stimulus
	initial begin
		stim_row_t rows[$];
		cache_clear();
		rows = '{
			'{OP_RELEASE, 16'h0, 31'h0, 5'd0, 1, '{5'd0, 0, 0, ST_COUNT}},
			'{OP_UNPIN, 16'h0, 31'h0, 5'd5, 1, '{5'd5, 0, 0, ST_COUNT}},
			'{OP_PIN, 16'h0, 31'h0, 5'd31, 1, '{5'd31, 0, 0, ST_COUNT}},
			'{OP_RELEASE, 16'h0, 31'h0, 5'd30, 1, '{5'd30, 0, 0, ST_COUNT}},
			'{OP_GET, 16'h0, 31'h0, 5'd0, 1, '{5'd26, 1, 1, ST_OK}},
			'{OP_GET, 16'h0, 31'h0, 5'd0, 0, '0},
			'{OP_GET, 16'hFFFF, 31'h7FFFFFFF, 5'd0, 0, '0},
			'{OP_GET, 16'hFFFF, 31'h7FFFFFFF, 5'd0, 0, '0},
			'{OP_GET, 16'h1234, 31'd13, 5'd0, 0, '0},
			'{OP_GET, 16'h1234, 31'd26, 5'd0, 0, '0},
			'{OP_GET, 16'h1234, 31'd39, 5'd0, 0, '0},
			'{OP_GET, 16'h1234, 31'd52, 5'd0, 0, '0},
			'{OP_PIN, 16'h0, 31'h0, 5'd29, 0, '0},
			'{OP_UNPIN, 16'h0, 31'h0, 5'd29, 0, '0},
			'{OP_UNPIN, 16'h0, 31'h0, 5'd29, 0, '0},
			'{OP_RELEASE, 16'h0, 31'h0, 5'd26, 0, '0},
			'{OP_RELEASE, 16'h0, 31'h0, 5'd26, 0, '0},
			'{OP_RELEASE, 16'h0, 31'h0, 5'd26, 0, '0},
			'{OP_GET, 16'h0, 31'h0, 5'd0, 0, '0}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		foreach (rows[i])
			send_request(rows[i].op, rows[i].dev, rows[i].blk, rows[i].idx,
				rows[i].known, rows[i].reply);
		// Drive one buffer to the count ceiling, then overflow by pin and by get
		for (int k = 0; k < 256; k++)
			send_request(OP_GET, 16'hBEEF, 31'd100, 5'd0, 0, '0);
		send_request(OP_PIN, 16'h0, 31'h0, 5'(cache_predict_id()), 0, '0);
		// Fill every buffer so a get finds none free
		for (int k = 0; k < 32; k++)
			send_request(OP_GET, 16'h7, 31'(1000 + k), 5'd0, 0, '0);
		for (int k = 0; k < NUM_BUFFERS; k++)
			while (tag_cnt[k] > 0 && tag_cnt[k] < 255)
				send_request(OP_RELEASE, 16'h0, 31'h0, 5'(k), 0, '0);
		hold_rx <= 1'b1;
		for (int k = 0; k < RANDOM_ITEMS; k++)
			send_random();
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver with random stalls and one long hold-off
	initial begin
		int stall;
		bit held;
		held = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx && !held) begin
				held = 1;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			out_ready <= 1'b0;
		end
	end

	// Reply checker
	always @(posedge clk) begin
		cache_reply_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				$error("reply with nothing expected: buffer %0d", result_buffer);
				errors++;
			end else begin
				exp_r = pending_replies.pop_front();
				if (result_buffer !== exp_r.buf_id) begin
					$error("result_buffer expected %0d actual %0d", exp_r.buf_id, result_buffer);
					errors++;
				end
				if (hit !== exp_r.hit) begin
					$error("hit expected %0d actual %0d", exp_r.hit, hit);
					errors++;
				end
				if (needs_disk_read !== exp_r.rd) begin
					$error("needs_disk_read expected %0d actual %0d", exp_r.rd, needs_disk_read);
					errors++;
				end
				if (status !== exp_r.st) begin
					$error("status expected %0d actual %0d", exp_r.st, status);
					errors++;
				end
			end
		end
	end

	// End of run and timeout
	initial begin
		fork
			begin
				while (!(stim_done && pending_replies.size() == 0))
					@(posedge clk);
				repeat (200) @(posedge clk);
			end
			begin
				while (cycle < CYCLE_LIMIT) begin
					@(posedge clk);
					cycle++;
				end
				errors++;
				$display("timeout after %0d cycles", cycle);
			end
		join_any
		if (errors == 0)
			$display("hashed_buffer_cache_manager test passed");
		else
			$display("hashed_buffer_cache_manager test failed");
		$finish;
	end
endmodule

[sim.f]
hw/rtl/hbcm_pkg.sv
hw/rtl/hbcm_ram.sv
hw/rtl/hbcm_mod.sv
hw/rtl/hashed_buffer_cache_manager.sv
verif/tb_top.sv
